### hdl/q2e_pkg.sv
// Shared constants, tables and types for the quaternion to Euler angle pipeline.
`timescale 1ns / 1ps

package q2e_pkg;

	localparam int COMPONENT_WIDTH     = 16;
	localparam int ANGLE_FRACTION_BITS = 7;

	localparam int QFRAC        = 30;
	localparam int PROD_W       = 34;
	localparam int SC_W         = 37;
	localparam int SP_W         = 31;
	localparam int XY_W         = 40;
	localparam int Z_W          = 34;
	localparam int RAD_W        = 31;
	localparam int PROD_RAD_W   = Z_W + RAD_W;
	localparam int MAG_W        = PROD_RAD_W + 1;
	localparam int ANG_W        = 26;
	localparam int CORDIC_STEPS = 30;
	localparam int ISQRT_STEPS  = 31;
	localparam int ISQRT_W      = 63;
	localparam int ATAN_LAT     = CORDIC_STEPS + 3;

	localparam logic signed [SC_W-1:0]    Q_ONE      = 37'sd1073741824;
	localparam logic [ISQRT_W-1:0]        Q_ONE_SQ   = 63'd1 << (2 * QFRAC);
	localparam logic signed [Z_W-1:0]     HALF_PI    = 34'sd1686629713;
	localparam logic signed [RAD_W-1:0]   RAD_TO_DEG = 31'sd961263669;

	localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
		34'sd33543515, 34'sd16775850, 34'sd8388437, 34'sd4194282, 34'sd2097149,
		34'sd1048575, 34'sd524287, 34'sd262143, 34'sd131071, 34'sd65535,
		34'sd32767, 34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047,
		34'sd1023, 34'sd511, 34'sd255, 34'sd127, 34'sd63,
		34'sd31, 34'sd15, 34'sd7, 34'sd3, 34'sd1
	};

	typedef struct packed {
		logic signed [SC_W-1:0] sr;
		logic signed [SC_W-1:0] cr;
		logic signed [SC_W-1:0] sy;
		logic signed [SC_W-1:0] cy;
		logic signed [SC_W-1:0] sp;
	} sc_set_t;

	typedef struct packed {
		logic clamp;
		logic pos;
	} pclamp_t;

endpackage

### hdl/q2e_quat_if.sv
// Quaternion input channel: valid, ready and the four components.
`timescale 1ns / 1ps

interface q2e_quat_if #(
	parameter int COMPONENT_WIDTH = q2e_pkg::COMPONENT_WIDTH
);
	logic                              valid;
	logic                              ready;
	logic signed [COMPONENT_WIDTH-1:0] quat_x;
	logic signed [COMPONENT_WIDTH-1:0] quat_y;
	logic signed [COMPONENT_WIDTH-1:0] quat_z;
	logic signed [COMPONENT_WIDTH-1:0] quat_w;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

### hdl/q2e_euler_if.sv
// Euler angle output channel: valid, ready, roll, pitch, yaw and clamp flag.
`timescale 1ns / 1ps

interface q2e_euler_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] roll_angle;
	logic signed [14:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic               pitch_clamped;

	modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
		input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
		output ready);
endinterface

### hdl/q2e_isqrt.sv
// Pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps

module q2e_isqrt (
	input  logic                         clk,
	input  logic                         en,
	input  logic [q2e_pkg::ISQRT_W-1:0]  n,
	output logic [q2e_pkg::ISQRT_W-1:0]  root
);
	localparam int W = q2e_pkg::ISQRT_W;
	localparam int STEPS = q2e_pkg::ISQRT_STEPS;

	logic [W-1:0] rem_s  [STEPS];
	logic [W-1:0] root_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [W-1:0] BIT = W'(1) << (2 * (STEPS - 1 - k));
		logic [W-1:0] rem_in;
		logic [W-1:0] root_in;
		logic [W-1:0] trial;

		if (k == 0) begin : g_first
			assign rem_in  = n;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign trial = root_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[k]  <= rem_in - trial;
					root_s[k] <= (root_in >> 1) + BIT;
				end else begin
					rem_s[k]  <= rem_in;
					root_s[k] <= root_in >> 1;
				end
			end
		end
	end

	assign root = root_s[STEPS-1];
endmodule

### hdl/q2e_atan2.sv
// Pipelined vectoring CORDIC atan2 with conversion to rounded, saturated degrees.
`timescale 1ns / 1ps

module q2e_atan2 #(
	parameter int ANGLE_FRACTION_BITS = q2e_pkg::ANGLE_FRACTION_BITS,
	parameter int DEG_LIMIT = 180
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [q2e_pkg::SC_W-1:0]    s,
	input  logic signed [q2e_pkg::SC_W-1:0]    c,
	output logic signed [q2e_pkg::ANG_W-1:0]   angle
);
	localparam int XW = q2e_pkg::XY_W;
	localparam int ZW = q2e_pkg::Z_W;
	localparam int PW = q2e_pkg::PROD_RAD_W;
	localparam int MW = q2e_pkg::MAG_W;
	localparam int AW = q2e_pkg::ANG_W;
	localparam int STEPS = q2e_pkg::CORDIC_STEPS;
	localparam int SH = q2e_pkg::QFRAC + 24 - ANGLE_FRACTION_BITS;
	localparam logic [MW-1:0] HALF_LSB = MW'(1) << (SH - 1);
	localparam logic [MW-1:0] LIM = MW'(DEG_LIMIT) << ANGLE_FRACTION_BITS;

	logic signed [XW-1:0] x_s [STEPS+1];
	logic signed [XW-1:0] y_s [STEPS+1];
	logic signed [ZW-1:0] z_s [STEPS+1];
	logic                 zero_s [STEPS+1];
	logic signed [PW-1:0] prod_s;

	logic [MW-1:0] mag;
	logic [MW-1:0] rnd;
	logic [MW-1:0] sat;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (s == '0) && (c == '0);
			if (c >= 0) begin
				x_s[0] <= XW'(c);
				y_s[0] <= XW'(s);
				z_s[0] <= '0;
			end else if (s >= 0) begin
				x_s[0] <= XW'(s);
				y_s[0] <= -(XW'(c));
				z_s[0] <= q2e_pkg::HALF_PI;
			end else begin
				x_s[0] <= -(XW'(s));
				y_s[0] <= XW'(c);
				z_s[0] <= -q2e_pkg::HALF_PI;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [XW-1:0] xsh;
		logic signed [XW-1:0] ysh;

		assign xsh = x_s[i] >>> i;
		assign ysh = y_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + ysh;
					y_s[i+1] <= y_s[i] - xsh;
					z_s[i+1] <= z_s[i] + q2e_pkg::ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] - ysh;
					y_s[i+1] <= y_s[i] + xsh;
					z_s[i+1] <= z_s[i] - q2e_pkg::ATAN_TAB[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[STEPS]) begin
				prod_s <= '0;
			end else begin
				prod_s <= PW'(z_s[STEPS]) * PW'(q2e_pkg::RAD_TO_DEG);
			end
		end
	end

	always_comb begin
		mag = (prod_s < 0) ? MW'(-prod_s) : MW'(prod_s);
		rnd = (mag + HALF_LSB) >> SH;
		sat = (rnd > LIM) ? LIM : rnd;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= (prod_s < 0) ? -(AW'(sat)) : AW'(sat);
		end
	end
endmodule

### hdl/quaternion_to_euler_top.sv
// Top level: quaternion to roll, pitch and yaw angle pipeline.
`timescale 1ns / 1ps

// Usage:
//   quat  : sink channel, one quaternion word (x, y, z, w) in signed
//           Q2.(COMPONENT_WIDTH-2), taken when valid and ready are high.
//   euler : source channel, one word per quaternion: roll, pitch, yaw in
//           1/2^ANGLE_FRACTION_BITS degree and the pitch clamp flag.
// Throughput: one word per cycle while the output is taken; the pipeline holds on a stall.
// Path: from acceptance to valid output a word passes through the chain of
//   4 product/sum stages, 31 square root stages (one root bit each),
//   a 33-stage CORDIC atan2 (pre-rotation, 30 iterations, scale, round)
//   and the output register.
// Stall: the whole pipeline holds while the output word waits; quat.ready
//   is high whenever the output register is empty or being taken, so no
//   bubble is inserted and nothing is lost or repeated.
// Reset: arst_n clears all valid bits; the pipeline comes out empty and
//   ready. Datapath registers are not reset.

module quaternion_to_euler_top #(
	parameter int COMPONENT_WIDTH     = q2e_pkg::COMPONENT_WIDTH,
	parameter int ANGLE_FRACTION_BITS = q2e_pkg::ANGLE_FRACTION_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	q2e_quat_if.sink     quat,
	q2e_euler_if.source  euler
);
	localparam int CW = COMPONENT_WIDTH;
	localparam int PW = q2e_pkg::PROD_W;
	localparam int SW = q2e_pkg::SC_W;
	localparam int SPW = q2e_pkg::SP_W;
	localparam int AW = q2e_pkg::ANG_W;
	localparam int PSHIFT = 2 * (CW - 2) - q2e_pkg::QFRAC;
	localparam int PSH_R = (PSHIFT >= 0) ? PSHIFT : 0;
	localparam int PSH_L = (PSHIFT < 0) ? -PSHIFT : 0;
	localparam int EXT_W = 2 * CW + PSH_L;
	localparam int SC_DLY = 2 + q2e_pkg::ISQRT_STEPS;
	localparam int PC_DLY = q2e_pkg::ATAN_LAT;
	localparam int LAT = 4 + q2e_pkg::ISQRT_STEPS + q2e_pkg::ATAN_LAT + 1;
	localparam logic signed [AW-1:0] PITCH_LIM = AW'(90) << ANGLE_FRACTION_BITS;

	function automatic logic signed [PW-1:0] prod_q(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		logic signed [2*CW-1:0] p;
		p = a * b;
		return PW'((EXT_W'(p) <<< PSH_L) >>> PSH_R);
	endfunction

	logic [LAT-1:0] vld_q;
	logic           adv;

	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;
	q2e_pkg::sc_set_t     sc_s2;
	logic signed [SPW-1:0] sp_n;
	logic [2*SPW-1:0]     sq_s3;
	logic [q2e_pkg::ISQRT_W-1:0] n_s4;
	logic [q2e_pkg::ISQRT_W-1:0] root;
	q2e_pkg::sc_set_t     sc_dly_s [SC_DLY];
	q2e_pkg::sc_set_t     sc_a;
	q2e_pkg::pclamp_t     pc_in;
	q2e_pkg::pclamp_t     pc_dly_s [PC_DLY];
	logic signed [SW-1:0] cp;
	logic signed [AW-1:0] roll_a, pitch_a, yaw_a;

	logic signed [15:0] roll_q;
	logic signed [14:0] pitch_q;
	logic signed [15:0] yaw_q;
	logic               clamp_q;

	assign adv = !vld_q[LAT-1] || euler.ready;
	assign quat.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], quat.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s1 <= prod_q(quat.quat_w, quat.quat_x);
			yz_s1 <= prod_q(quat.quat_y, quat.quat_z);
			xx_s1 <= prod_q(quat.quat_x, quat.quat_x);
			yy_s1 <= prod_q(quat.quat_y, quat.quat_y);
			wz_s1 <= prod_q(quat.quat_w, quat.quat_z);
			xy_s1 <= prod_q(quat.quat_x, quat.quat_y);
			zz_s1 <= prod_q(quat.quat_z, quat.quat_z);
			wy_s1 <= prod_q(quat.quat_w, quat.quat_y);
			zx_s1 <= prod_q(quat.quat_z, quat.quat_x);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_s2.sr <= (SW'(wx_s1) + SW'(yz_s1)) <<< 1;
			sc_s2.cr <= q2e_pkg::Q_ONE - ((SW'(xx_s1) + SW'(yy_s1)) <<< 1);
			sc_s2.sy <= (SW'(wz_s1) + SW'(xy_s1)) <<< 1;
			sc_s2.cy <= q2e_pkg::Q_ONE - ((SW'(yy_s1) + SW'(zz_s1)) <<< 1);
			sc_s2.sp <= (SW'(wy_s1) - SW'(zx_s1)) <<< 1;
		end
	end

	// pitch cosine: sqrt(1 - sp^2), only meaningful when not clamped
	assign sp_n = sc_s2.sp[SPW-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s3 <= unsigned'((2 * SPW)'(sp_n) * (2 * SPW)'(sp_n));
			n_s4  <= q2e_pkg::Q_ONE_SQ - q2e_pkg::ISQRT_W'(sq_s3);
		end
	end

	q2e_isqrt u_isqrt (
		.clk  (clk),
		.en   (adv),
		.n    (n_s4),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_dly_s[0] <= sc_s2;
			for (int j = 1; j < SC_DLY; j++) begin
				sc_dly_s[j] <= sc_dly_s[j-1];
			end
		end
	end

	assign sc_a = sc_dly_s[SC_DLY-1];
	assign cp = SW'(root);
	assign pc_in.clamp = (sc_a.sp >= q2e_pkg::Q_ONE) || (sc_a.sp <= -q2e_pkg::Q_ONE);
	assign pc_in.pos = sc_a.sp > 0;

	always_ff @(posedge clk) begin
		if (adv) begin
			pc_dly_s[0] <= pc_in;
			for (int j = 1; j < PC_DLY; j++) begin
				pc_dly_s[j] <= pc_dly_s[j-1];
			end
		end
	end

	q2e_atan2 #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .DEG_LIMIT(180)) u_roll (
		.clk   (clk),
		.en    (adv),
		.s     (sc_a.sr),
		.c     (sc_a.cr),
		.angle (roll_a)
	);

	q2e_atan2 #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .DEG_LIMIT(180)) u_yaw (
		.clk   (clk),
		.en    (adv),
		.s     (sc_a.sy),
		.c     (sc_a.cy),
		.angle (yaw_a)
	);

	q2e_atan2 #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .DEG_LIMIT(90)) u_pitch (
		.clk   (clk),
		.en    (adv),
		.s     (sc_a.sp),
		.c     (cp),
		.angle (pitch_a)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			roll_q  <= roll_a[15:0];
			yaw_q   <= yaw_a[15:0];
			clamp_q <= pc_dly_s[PC_DLY-1].clamp;
			if (pc_dly_s[PC_DLY-1].clamp) begin
				pitch_q <= pc_dly_s[PC_DLY-1].pos ? PITCH_LIM[14:0] : -PITCH_LIM[14:0];
			end else begin
				pitch_q <= pitch_a[14:0];
			end
		end
	end

	assign euler.valid         = vld_q[LAT-1];
	assign euler.roll_angle    = roll_q;
	assign euler.pitch_angle   = pitch_q;
	assign euler.yaw_angle     = yaw_q;
	assign euler.pitch_clamped = clamp_q;
endmodule

### hdl/q2e_checker.sv
// Port-level checks for the quaternion to Euler pipeline, bound to the top level.
`timescale 1ns / 1ps

module q2e_checker #(
	parameter int ANGLE_FRACTION_BITS = q2e_pkg::ANGLE_FRACTION_BITS
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] roll,
	input logic [14:0] pitch,
	input logic [15:0] yaw,
	input logic        clamped
);
	localparam logic [14:0] PL = 15'(90 << ANGLE_FRACTION_BITS);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({roll, pitch, yaw, clamped}))
		else $error("output word changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clamped |-> (pitch == PL) || (pitch == 15'(-PL)))
		else $error("clamped pitch is not at +-90 degrees");

	a_no_stall_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");
endmodule

bind quaternion_to_euler_top q2e_checker #(
	.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
) u_q2e_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (quat.ready),
	.out_valid (euler.valid),
	.out_ready (euler.ready),
	.roll      (euler.roll_angle),
	.pitch     (euler.pitch_angle),
	.yaw       (euler.yaw_angle),
	.clamped   (euler.pitch_clamped)
);
